@@ rtl/core/nfca_pkg.sv @@
// Shared types, constants and helpers of the nearest free cell allocator.
`default_nettype none

package nfca_pkg;

    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;
    localparam int FIELD_W      = 7;
    localparam int DIST_W       = 8;

    // Register select, taken from paddr[2]
    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_COL_COUNT = 1'b1;

    // Result of the column search on one row word
    typedef struct packed {
        logic               vld;
        logic               found;
        logic [FIELD_W-1:0] cdist;
    } t_pick_stat;

    function automatic int addr_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/nearest_free_cell_allocator.sv @@
// Flow: an accepted item reads one row word per cycle from the occupancy map, then
//   goes through column search, row compare and write-back; with no rows in use it
//   goes straight to the result. A stalled output holds the result and write-back.
// A new item may be accepted while the previous result still waits in the output register.
// Reset: synchronous, active low. Counts go to 64; the map is then cleared by a pass
//   over all MAX_ROWS rows during which s_axis_tready stays low.
`default_nettype none

module nearest_free_cell_allocator import nfca_pkg::*; #(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // request: [6:0] want_row, [13:7] want_col, [15:14] zero
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,
    // result: [6:0] seat_row, [13:7] seat_col, [15:14] zero
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,
    // result: [0] found
    output logic [0:0]  m_axis_tuser,
    // configuration
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int ROW_AW = addr_w(MAX_ROWS);
    localparam int COL_AW = addr_w(MAX_COLS);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_DONE} t_state;

    t_state               r_state;
    logic [FIELD_W-1:0]   r_row_count, r_col_count;
    logic [FIELD_W-1:0]   rows_eff, cols_eff;
    logic [FIELD_W-1:0]   r_want_row, r_want_col;
    logic [ROW_AW-1:0]    r_addr;
    logic                 r_out_vld, r_out_found;
    logic [FIELD_W-1:0]   r_out_row, r_out_col;

    // running best over the scanned rows
    logic                 r_have;
    logic [DIST_W-1:0]    r_best_d;
    logic [ROW_AW-1:0]    r_best_r;
    logic [COL_AW-1:0]    r_best_c;
    logic [MAX_COLS-1:0]  r_best_word;

    logic                 mem_rd_en, mem_rd_vld, mem_wr_en, clearing;
    logic [ROW_AW-1:0]    mem_rd_row, pick_row;
    logic [MAX_COLS-1:0]  mem_rd_data, mem_wr_data, pick_word;
    t_pick_stat           pick;
    logic [COL_AW-1:0]    pick_col;
    logic [DIST_W-1:0]    row1, want_r, rdist, cell_dist;
    logic                 in_fire, out_free, last_row, cfg_wr;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= FIELD_W'(64);
            r_col_count <= FIELD_W'(64);
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_ROW_COUNT: r_row_count <= pwdata[FIELD_W-1:0];
                REG_COL_COUNT: r_col_count <= pwdata[FIELD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_ROW_COUNT: prdata = {{(32-FIELD_W){1'b0}}, r_row_count};
            REG_COL_COUNT: prdata = {{(32-FIELD_W){1'b0}}, r_col_count};
            default:       prdata = '0;
        endcase
    end

    // counts above the build maximum are clamped
    assign rows_eff = (int'(r_row_count) > MAX_ROWS) ? FIELD_W'(MAX_ROWS) : r_row_count;
    assign cols_eff = (int'(r_col_count) > MAX_COLS) ? FIELD_W'(MAX_COLS) : r_col_count;

    // ---------------- map and column search ----------------
    nfca_map #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .ROW_AW   (ROW_AW)
    ) u_map (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (mem_rd_en),
        .i_rd_addr  (r_addr),
        .o_rd_vld   (mem_rd_vld),
        .o_rd_row   (mem_rd_row),
        .o_rd_data  (mem_rd_data),
        .i_wr_en    (mem_wr_en),
        .i_wr_addr  (r_best_r),
        .i_wr_data  (mem_wr_data),
        .o_clearing (clearing)
    );

    nfca_colpick #(
        .MAX_COLS (MAX_COLS),
        .ROW_AW   (ROW_AW),
        .COL_AW   (COL_AW)
    ) u_colpick (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (mem_rd_vld),
        .i_row      (mem_rd_row),
        .i_word     (mem_rd_data),
        .i_cols     (cols_eff),
        .i_want_col (r_want_col),
        .o_stat     (pick),
        .o_col      (pick_col),
        .o_row      (pick_row),
        .o_word     (pick_word)
    );

    // ---------------- control ----------------
    assign s_axis_tready = (r_state == S_IDLE) && !clearing;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_vld || m_axis_tready;
    assign last_row      = (int'(r_addr) + 1) == int'(rows_eff);
    assign mem_rd_en     = (r_state == S_SCAN);
    // map is only written once the result goes to the output register
    assign mem_wr_en     = (r_state == S_DONE) && out_free && r_have;
    assign mem_wr_data   = r_best_word | (MAX_COLS'(1) << r_best_c);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_addr    <= '0;
        end else begin
            if ((r_state == S_DONE) && out_free) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_addr  <= '0;
                        r_state <= (rows_eff == '0) ? S_DRAIN : S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_addr <= r_addr + 1'b1;
                    if (last_row) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!mem_rd_vld && !pick.vld) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_found <= r_have;
                        r_out_row   <= r_have ? FIELD_W'(r_best_r) + 1'b1 : '0;
                        r_out_col   <= r_have ? FIELD_W'(r_best_c) + 1'b1 : '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_want_row <= s_axis_tdata[6:0];
            r_want_col <= s_axis_tdata[13:7];
        end
    end

    // row distance plus column distance; strict less keeps the earlier row on a tie
    assign row1      = DIST_W'(pick_row) + 1'b1;
    assign want_r    = {1'b0, r_want_row};
    assign rdist     = (row1 >= want_r) ? (row1 - want_r) : (want_r - row1);
    assign cell_dist = rdist + {1'b0, pick.cdist};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (in_fire) begin
            r_have <= 1'b0;
        end else if (pick.vld && pick.found && (!r_have || (cell_dist < r_best_d))) begin
            r_have <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pick.vld && pick.found && (!r_have || (cell_dist < r_best_d))) begin
            r_best_d    <= cell_dist;
            r_best_r    <= pick_row;
            r_best_c    <= pick_col;
            r_best_word <= pick_word;
        end
    end

    assign m_axis_tvalid   = r_out_vld;
    assign m_axis_tdata    = {2'b00, r_out_col, r_out_row};
    assign m_axis_tuser[0] = r_out_found;

    // ---------------- checks ----------------
    a_no_write_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !mem_wr_en)
        else $error("map written during clearing pass");

    a_zero_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[13:0] == 14'd0))
        else $error("nonzero cell on grid-full result");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == S_SCAN || r_state == S_DRAIN))
        else $error("accepted item did not start a scan");

    a_pick_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pick.vld |-> (r_state == S_SCAN || r_state == S_DRAIN))
        else $error("column result outside a scan");

    a_found_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |->
            (m_axis_tdata[6:0] != 7'd0 && m_axis_tdata[13:7] != 7'd0))
        else $error("found result with zero row or column");

endmodule

`default_nettype wire

@@ rtl/core/nfca_map.sv @@
// Occupancy map: one row word per entry, registered read, reset clearing pass.
`default_nettype none

module nfca_map import nfca_pkg::*; #(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int ROW_AW   = addr_w(DEF_MAX_ROWS)
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_rd_en,
    input  wire  [ROW_AW-1:0]   i_rd_addr,
    output logic                o_rd_vld,
    output logic [ROW_AW-1:0]   o_rd_row,
    output logic [MAX_COLS-1:0] o_rd_data,
    input  wire                 i_wr_en,
    input  wire  [ROW_AW-1:0]   i_wr_addr,
    input  wire  [MAX_COLS-1:0] i_wr_data,
    output logic                o_clearing
);

    logic [MAX_COLS-1:0] r_mem [MAX_ROWS];
    logic [ROW_AW-1:0]   r_clr_addr;
    logic                r_clearing;
    logic                r_rd_vld;

    // clear sweep, one row per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == ROW_AW'(MAX_ROWS - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
            o_rd_row  <= i_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_rd_en;
        end
    end

    assign o_rd_vld   = r_rd_vld;
    assign o_clearing = r_clearing;

endmodule

`default_nettype wire

@@ rtl/core/nfca_colpick.sv @@
// Nearest free column in one row word, registered.
`default_nettype none

module nfca_colpick import nfca_pkg::*; #(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int ROW_AW   = addr_w(DEF_MAX_ROWS),
    parameter int COL_AW   = addr_w(DEF_MAX_COLS)
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_vld,
    input  wire  [ROW_AW-1:0]   i_row,
    input  wire  [MAX_COLS-1:0] i_word,
    input  wire  [FIELD_W-1:0]  i_cols,
    input  wire  [FIELD_W-1:0]  i_want_col,
    output t_pick_stat          o_stat,
    output logic [COL_AW-1:0]   o_col,
    output logic [ROW_AW-1:0]   o_row,
    output logic [MAX_COLS-1:0] o_word
);

    logic              left_ok, right_ok, free_c, pick_left;
    logic [COL_AW-1:0] left_col, right_col;
    logic [DIST_W-1:0] want_x, ldist, rdist;
    t_pick_stat        r_stat;

    assign want_x = {1'b0, i_want_col};

    // left: highest free column at or below the wanted one; right: lowest above
    always_comb begin
        left_ok   = 1'b0;
        right_ok  = 1'b0;
        left_col  = '0;
        right_col = '0;
        free_c    = 1'b0;
        for (int c = 0; c < MAX_COLS; c++) begin
            free_c = !i_word[c] && (DIST_W'(c) < {1'b0, i_cols});
            if (free_c && (DIST_W'(c + 1) <= want_x)) begin
                left_ok  = 1'b1;
                left_col = COL_AW'(c);
            end
            if (free_c && (DIST_W'(c + 1) > want_x) && !right_ok) begin
                right_ok  = 1'b1;
                right_col = COL_AW'(c);
            end
        end
    end

    assign ldist     = want_x - (DIST_W'(left_col) + 1'b1);
    assign rdist     = (DIST_W'(right_col) + 1'b1) - want_x;
    // tie goes to the smaller column
    assign pick_left = left_ok && (!right_ok || (ldist <= rdist));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stat <= '0;
        end else begin
            r_stat.vld   <= i_vld;
            r_stat.found <= left_ok || right_ok;
            r_stat.cdist <= pick_left ? ldist[FIELD_W-1:0] : rdist[FIELD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            o_col  <= pick_left ? left_col : right_col;
            o_row  <= i_row;
            o_word <= i_word;
        end
    end

    assign o_stat = r_stat;

endmodule

`default_nettype wire

@@ test/seat_checker.sv @@
// Checker for the nearest free cell allocator: tracks the grid, predicts each seat, compares.
`timescale 1ns / 1ps

module seat_checker import nfca_pkg::*; #(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_req_valid,
    input  wire         i_req_ready,
    input  wire  [15:0] i_req_data,     // [6:0] want_row, [13:7] want_col
    input  wire         i_seat_valid,
    input  wire         i_seat_ready,
    input  wire  [15:0] i_seat_data,    // [6:0] seat_row, [13:7] seat_col
    input  wire  [0:0]  i_seat_found,
    input  wire         i_psel,
    input  wire         i_penable,
    input  wire         i_pwrite,
    input  wire         i_pready,
    input  wire  [2:0]  i_paddr,
    input  wire  [31:0] i_pwdata,
    output int          o_pending,
    output int          o_fail_count
);

    typedef struct packed {
        logic [FIELD_W-1:0] row;
        logic [FIELD_W-1:0] col;
        logic               found;
    } t_seat;

    logic [MAX_COLS-1:0] taken_map [MAX_ROWS];
    logic [FIELD_W-1:0]  rows_cfg = 7'd64;
    logic [FIELD_W-1:0]  cols_cfg = 7'd64;
    t_seat               seat_queue [$];
    int                  fail_total = 0;

    assign o_fail_count = fail_total;

    task automatic report_mismatch(input string what, input int got, input int exp);
        $display("seat_checker: %s: got %0d, expected %0d at %0t", what, got, exp, $realtime);
        fail_total++;
    endtask

    function automatic int span(input int a, input int b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Full scan in row-major order; strict less-than keeps the first minimum,
    // which is the smaller row, then the smaller column.
    function automatic t_seat pick_nearest_seat(input logic [FIELD_W-1:0] want_row,
                                                input logic [FIELD_W-1:0] want_col);
        t_seat best;
        int    rows_used;
        int    cols_used;
        int    cell_dist;
        int    best_dist;
        best      = '0;
        best_dist = 0;
        rows_used = (rows_cfg > MAX_ROWS) ? MAX_ROWS : int'(rows_cfg);
        cols_used = (cols_cfg > MAX_COLS) ? MAX_COLS : int'(cols_cfg);
        for (int r = 0; r < rows_used; r++) begin
            for (int c = 0; c < cols_used; c++) begin
                if (taken_map[r][c])
                    continue;
                cell_dist = span(r + 1, int'(want_row)) + span(c + 1, int'(want_col));
                if (!best.found || cell_dist < best_dist) begin
                    best.found = 1'b1;
                    best.row   = FIELD_W'(r + 1);
                    best.col   = FIELD_W'(c + 1);
                    best_dist  = cell_dist;
                end
            end
        end
        return best;
    endfunction

    always @(posedge i_clk) begin
        t_seat due;
        t_seat got;
        if (!i_rst_n) begin
            foreach (taken_map[r])
                taken_map[r] = '0;
            rows_cfg = 7'd64;
            cols_cfg = 7'd64;
            seat_queue.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[2])
                    REG_ROW_COUNT: rows_cfg = i_pwdata[FIELD_W-1:0];
                    REG_COL_COUNT: cols_cfg = i_pwdata[FIELD_W-1:0];
                endcase
            end
            if (i_req_valid && i_req_ready) begin
                due = pick_nearest_seat(i_req_data[6:0], i_req_data[13:7]);
                if (due.found)
                    taken_map[due.row - 1][due.col - 1] = 1'b1;
                seat_queue = {seat_queue, due};
            end
            if (i_seat_valid && i_seat_ready) begin
                got.row   = i_seat_data[6:0];
                got.col   = i_seat_data[13:7];
                got.found = i_seat_found[0];
                if (seat_queue.size() == 0) begin
                    report_mismatch("seat with no request pending", got.row, 0);
                end else begin
                    due = seat_queue.pop_front();
                    if (got.row != due.row)
                        report_mismatch("seat_row", got.row, due.row);
                    if (got.col != due.col)
                        report_mismatch("seat_col", got.col, due.col);
                    if (got.found != due.found)
                        report_mismatch("found", got.found, due.found);
                    if (i_seat_data[15:14] != 2'b00)
                        report_mismatch("tdata padding", i_seat_data[15:14], 0);
                end
            end
        end
        o_pending <= seat_queue.size();
    end

endmodule

@@ test/tb_nearest_free_cell_allocator.sv @@
// Testbench top: drives requests, register writes and output stalls, and gives the verdict.
`timescale 1ns / 1ps

module tb_nearest_free_cell_allocator import nfca_pkg::*; ();

    localparam int RANDOM_ITEMS = 1000;
    localparam int SETTLE_CYCLES = 80;     // settle time after the last seat, plus margin
    localparam int HOLD_CYCLES   = 400;    // long output stall, fills the block
    localparam int QUIET_LIMIT   = 5000;   // cycles with no item moving on either side

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;        // [6:0] want_row, [13:7] want_col, [15:14] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;             // [6:0] seat_row, [13:7] seat_col, [15:14] zero
    logic [0:0]  m_axis_tuser;             // [0] found

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int          seats_pending;
    int          mismatch_count;

    // Pacing knobs shared between stimulus and the output side
    bit          sender_steady = 1'b0;
    bit          sink_steady = 1'b0;
    bit          hold_sink = 1'b0;
    int          random_sent = 0;
    int          quiet_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    nearest_free_cell_allocator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    seat_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_axis_tvalid),
        .i_req_ready  (s_axis_tready),
        .i_req_data   (s_axis_tdata),
        .i_seat_valid (m_axis_tvalid),
        .i_seat_ready (m_axis_tready),
        .i_seat_data  (m_axis_tdata),
        .i_seat_found (m_axis_tuser),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_pending    (seats_pending),
        .o_fail_count (mismatch_count)
    );

    // One request item. Valid stays up between back-to-back items; it only
    // drops when a gap is drawn, so it never gets two updates in one step.
    task automatic send_request(input logic [6:0] want_row, input logic [6:0] want_col);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, want_col, want_row};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Drop valid, wait for every seat to come back, then let the last
    // (possibly resultless) work finish before touching a register.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (seats_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup phase, access phase, then an idle phase; upper data
    // bits are noise the block must drop.
    task automatic write_reg(input logic reg_sel, input logic [6:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= {25'($urandom()), value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_grid(input logic [6:0] rows, input logic [6:0] cols);
        drain_results();
        write_reg(REG_ROW_COUNT, rows);
        write_reg(REG_COL_COUNT, cols);
    endtask

    // Mostly inside the grid in use; now and then anywhere in the 7-bit range.
    function automatic logic [6:0] draw_want(input logic [6:0] count);
        int used;
        used = (count > 64) ? 64 : int'(count);
        if (used == 0 || $urandom_range(0, 6) == 0)
            return 7'($urandom_range(0, 127));
        return 7'($urandom_range(1, used));
    endfunction

    function automatic logic [6:0] draw_count();
        case ($urandom_range(0, 11))
            0:       return 7'd64;
            1:       return 7'd1;
            2:       return 7'd127;
            3:       return 7'($urandom_range(65, 126));
            4, 5, 6: return 7'($urandom_range(1, 8));
            default: return 7'($urandom_range(1, 64));
        endcase
    endfunction

    // Output side: a random stall before each item (none when steady), or one long hold when asked.
    initial begin : sink
        int wait_cycles;
        forever begin
            wait_cycles = sink_steady ? 0 : $urandom_range(0, 19);
            if (hold_sink) begin
                wait_cycles = HOLD_CYCLES;
                hold_sink   = 1'b0;
            end
            if (wait_cycles > 0) begin
                m_axis_tready <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // Watchdog on progress: any item moving on either side resets it.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin : stimulus
        logic [6:0] rows;
        logic [6:0] cols;
        int         batch;
        int         phase;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: full 64x64 grid after reset (clear pass is covered by tready)
        send_request(7'd1, 7'd1);
        send_request(7'd1, 7'd1);       // tie between right and below: the earlier row wins
        send_request(7'd64, 7'd64);
        send_request(7'd64, 7'd64);
        send_request(7'd0, 7'd0);       // wanted point outside, all-zero fields
        send_request(7'd127, 7'd127);   // outside, all-one fields
        send_request(7'd0, 7'd127);
        send_request(7'd127, 7'd0);
        send_request(7'd64, 7'd1);
        send_request(7'd1, 7'd64);
        repeat (5) send_request(7'd32, 7'd32);  // ring fills around the center
        send_request(7'd65, 7'd65);

        // Single cell, already taken: grid full
        set_grid(7'd1, 7'd1);
        send_request(7'd1, 7'd1);
        send_request(7'd127, 7'd127);
        // Zero counts: nothing in use
        set_grid(7'd0, 7'd64);
        send_request(7'd1, 7'd1);
        set_grid(7'd64, 7'd0);
        send_request(7'd1, 7'd1);
        // Counts above the maximum clamp to it
        set_grid(7'd127, 7'd127);
        send_request(7'd127, 7'd127);
        send_request(7'd100, 7'd3);
        // Shrunk grid with taken cells outside it
        set_grid(7'd2, 7'd2);
        repeat (4) send_request(7'd2, 7'd2);

        // Random phases, each with its own grid and pacing
        phase = 0;
        while (random_sent < RANDOM_ITEMS) begin
            rows = draw_count();
            cols = draw_count();
            set_grid(rows, cols);
            batch         = $urandom_range(30, 100);
            sender_steady = ($urandom_range(0, 3) == 0);
            sink_steady   = ($urandom_range(0, 3) == 0);
            if (phase == 1) begin
                // Long output hold with the input kept busy
                sender_steady = 1'b1;
                sink_steady   = 1'b0;
                hold_sink     = 1'b1;
            end
            repeat (batch) begin
                send_request(draw_want(rows), draw_want(cols));
                random_sent++;
            end
            phase++;
        end

        drain_results();
        if (mismatch_count == 0 && seats_pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/nfca_pkg.sv
rtl/core/nfca_map.sv
rtl/core/nfca_colpick.sv
rtl/core/nearest_free_cell_allocator.sv
test/seat_checker.sv
test/tb_nearest_free_cell_allocator.sv
